// File: rtl/core/pbam_pkg.sv
// Shared types and range constants for the point / bit-byte address mapper.
package pbam_pkg;

    typedef enum logic [1:0] {
        CAT_NONE   = 2'd0,
        CAT_STATUS = 2'd1,
        CAT_TWOWAY = 2'd2,
        CAT_PSEUDO = 2'd3
    } t_category;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_REV = 1'b1
    } t_direction;

    typedef struct packed {
        logic      valid;
        logic [15:0] number;
        t_category category;
    } t_result;

    // Forward (point number) ranges.
    localparam logic [15:0] FWD_STATUS_HI = 16'd2047;
    localparam logic [15:0] FWD_DIG_LO    = 16'd10000;
    localparam logic [15:0] FWD_DIG_HI    = 16'd11023;
    localparam logic [15:0] FWD_DA_LO     = 16'd15000;
    localparam logic [15:0] FWD_DA_HI     = 16'd16023;
    localparam logic [15:0] FWD_BLK0_LO   = 16'd25000;
    localparam logic [15:0] FWD_BLK0_HI   = 16'd25063;
    localparam logic [15:0] FWD_BLK1_LO   = 16'd36000;
    localparam logic [15:0] FWD_BLK1_HI   = 16'd36063;
    localparam logic [15:0] FWD_BLK2_LO   = 16'd36088;
    localparam logic [15:0] FWD_BLK2_HI   = 16'd36095;
    localparam logic [15:0] FWD_PSEUDO_LO = 16'd50000;
    localparam logic [15:0] FWD_PSEUDO_HI = 16'd51192;

    // Reverse (bit/byte address) ranges.
    localparam logic [15:0] REV_DIG_HI    = 16'd2047;
    localparam logic [15:0] REV_DA_HI     = 16'd4095;
    localparam logic [15:0] REV_BLK0_LO   = 16'd4608;
    localparam logic [15:0] REV_BLK0_HI   = 16'd4727;
    localparam logic [15:0] REV_BLK1_LO   = 16'd5632;
    localparam logic [15:0] REV_BLK1_HI   = 16'd5751;
    localparam logic [15:0] REV_BLK2_LO   = 16'd5808;
    localparam logic [15:0] REV_BLK2_HI   = 16'd5815;
    localparam logic [15:0] REV_PSEUDO_LO = 16'd7000;
    localparam logic [15:0] REV_PSEUDO_HI = 16'd8192;
    localparam logic [15:0] REV_STATUS_LO = 16'd8193;
    localparam logic [15:0] REV_STATUS_HI = 16'd10240;

    // Offset between a pseudo point number and its address.
    localparam logic [15:0] PSEUDO_SHIFT  = 16'd43000;

endpackage

// File: rtl/core/pbam_fwd.sv
// Forward translation: point number to bit/byte address.
module pbam_fwd
    import pbam_pkg::*;
(
    input  logic [15:0] i_point,
    output t_result     o_res
);

    logic [15:0] d_dig;
    logic [15:0] d_da;
    logic [15:0] d_blk0;
    logic [15:0] d_blk1;
    logic [15:0] d_blk2;

    assign d_dig  = i_point - FWD_DIG_LO;
    assign d_da   = i_point - FWD_DA_LO;
    assign d_blk0 = i_point - FWD_BLK0_LO;
    assign d_blk1 = i_point - FWD_BLK1_LO;
    assign d_blk2 = i_point - FWD_BLK2_LO;

    // Block ranges put eight points into each sixteen-slot group, so the
    // group index moves up one bit and slot bit 3 stays clear.
    always_comb begin
        o_res = '{valid: 1'b0, number: 16'd0, category: CAT_NONE};
        if (i_point <= FWD_STATUS_HI) begin
            o_res = '{valid: 1'b1, number: i_point + REV_STATUS_LO, category: CAT_STATUS};
        end else if (i_point >= FWD_DIG_LO && i_point <= FWD_DIG_HI) begin
            o_res = '{valid: 1'b1, number: {5'd0, d_dig[9:0], 1'b0},
                      category: CAT_TWOWAY};
        end else if (i_point >= FWD_DA_LO && i_point <= FWD_DA_HI) begin
            o_res = '{valid: 1'b1, number: {4'd0, 1'b1, d_da[9:0], 1'b0},
                      category: CAT_NONE};
        end else if (i_point >= FWD_BLK0_LO && i_point <= FWD_BLK0_HI) begin
            o_res = '{valid: 1'b1,
                      number: REV_BLK0_LO + {9'd0, d_blk0[5:3], 1'b0, d_blk0[2:0]},
                      category: CAT_NONE};
        end else if (i_point >= FWD_BLK1_LO && i_point <= FWD_BLK1_HI) begin
            o_res = '{valid: 1'b1,
                      number: REV_BLK1_LO + {9'd0, d_blk1[5:3], 1'b0, d_blk1[2:0]},
                      category: CAT_NONE};
        end else if (i_point >= FWD_BLK2_LO && i_point <= FWD_BLK2_HI) begin
            o_res = '{valid: 1'b1, number: REV_BLK2_LO + {13'd0, d_blk2[2:0]},
                      category: CAT_NONE};
        end else if (i_point >= FWD_PSEUDO_LO && i_point <= FWD_PSEUDO_HI) begin
            o_res = '{valid: 1'b1, number: i_point - PSEUDO_SHIFT, category: CAT_PSEUDO};
        end
    end

endmodule

// File: rtl/core/pbam_rev.sv
// Reverse translation: bit/byte address to point number.
module pbam_rev
    import pbam_pkg::*;
(
    input  logic [15:0] i_addr,
    output t_result     o_res
);

    logic [15:0] d_blk0;
    logic [15:0] d_blk1;
    logic [15:0] d_blk2;

    assign d_blk0 = i_addr - REV_BLK0_LO;
    assign d_blk1 = i_addr - REV_BLK1_LO;
    assign d_blk2 = i_addr - REV_BLK2_LO;

    // Odd addresses in the digital ranges and the upper half of each block
    // group have no point behind them.
    always_comb begin
        o_res = '{valid: 1'b0, number: 16'd0, category: CAT_NONE};
        if (i_addr <= REV_DIG_HI) begin
            if (!i_addr[0]) begin
                o_res = '{valid: 1'b1, number: FWD_DIG_LO + {6'd0, i_addr[10:1]},
                          category: CAT_TWOWAY};
            end
        end else if (i_addr <= REV_DA_HI) begin
            if (!i_addr[0]) begin
                o_res = '{valid: 1'b1, number: FWD_DA_LO + {6'd0, i_addr[10:1]},
                          category: CAT_NONE};
            end
        end else if (i_addr >= REV_BLK0_LO && i_addr <= REV_BLK0_HI) begin
            if (!d_blk0[3]) begin
                o_res = '{valid: 1'b1,
                          number: FWD_BLK0_LO + {10'd0, d_blk0[6:4], d_blk0[2:0]},
                          category: CAT_NONE};
            end
        end else if (i_addr >= REV_BLK1_LO && i_addr <= REV_BLK1_HI) begin
            if (!d_blk1[3]) begin
                o_res = '{valid: 1'b1,
                          number: FWD_BLK1_LO + {10'd0, d_blk1[6:4], d_blk1[2:0]},
                          category: CAT_NONE};
            end
        end else if (i_addr >= REV_BLK2_LO && i_addr <= REV_BLK2_HI) begin
            o_res = '{valid: 1'b1, number: FWD_BLK2_LO + {13'd0, d_blk2[2:0]},
                      category: CAT_NONE};
        end else if (i_addr >= REV_PSEUDO_LO && i_addr <= REV_PSEUDO_HI) begin
            o_res = '{valid: 1'b1, number: i_addr + PSEUDO_SHIFT, category: CAT_PSEUDO};
        end else if (i_addr >= REV_STATUS_LO && i_addr <= REV_STATUS_HI) begin
            o_res = '{valid: 1'b1, number: i_addr - REV_STATUS_LO, category: CAT_STATUS};
        end
    end

endmodule

// File: rtl/core/point_bitbyte_address_mapper_core.sv
// Top level: two-stage stream wrapper around the forward and reverse mappers.
// A result is offered on the master side once its input has passed the input register
// and then the result register; a master-side stall can hold it in either register.
// Throughput: one transfer per cycle while m_axis_tready stays high; the input and
// result registers each advance whenever the stage behind them is empty or being drained.
// Both range translators are short compare-and-add logic between those two registers.
// Reset (i_rst_n low, synchronous) empties both stages; no result is pending after it.
module point_bitbyte_address_mapper_core
    import pbam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] number_in
    input  logic        s_axis_tuser,  // [0] func (0 forward, 1 reverse)
    // Master side.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] number_out
    output logic [2:0]  m_axis_tuser   // [0] valid_res, [2:1] category
);

    // Input stage registers.
    logic        r_in_valid;
    logic        n_in_valid;
    t_direction  r_dir;
    logic [15:0] r_num;

    // Result stage registers.
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_res;

    logic        in_ready;
    logic        res_ready;
    t_result     fwd_res;
    t_result     rev_res;
    t_result     sel_res;

    // A stage can take new data when it is empty or its content moves on
    // in the same cycle.
    assign res_ready = !r_out_valid || m_axis_tready;
    assign in_ready  = !r_in_valid || res_ready;

    assign n_in_valid  = s_axis_tvalid ? 1'b1 : (r_in_valid && !res_ready);
    assign n_out_valid = r_in_valid ? 1'b1 : (r_out_valid && !m_axis_tready);

    pbam_fwd u_fwd (
        .i_point (r_num),
        .o_res   (fwd_res)
    );

    pbam_rev u_rev (
        .i_addr  (r_num),
        .o_res   (rev_res)
    );

    always_comb begin
        case (r_dir)
            DIR_FWD: sel_res = fwd_res;
            DIR_REV: sel_res = rev_res;
            default: sel_res = fwd_res;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= n_in_valid;
            end
            if (res_ready) begin
                r_out_valid <= n_out_valid;
            end
        end
    end

    // Payload moves only on a transfer into each stage.
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_dir <= t_direction'(s_axis_tuser);
            r_num <= s_axis_tdata;
        end
        if (res_ready && r_in_valid) begin
            r_res <= sel_res;
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_res.number;
    assign m_axis_tuser  = {r_res.category, r_res.valid};

endmodule

// File: rtl/core/pbam_checker.sv
// Port-level assertions for the mapper core and the bind that attaches them.
module pbam_checker
    import pbam_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A rejected translation carries no number and no category.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tdata == 16'd0 && m_axis_tuser[2:1] == CAT_NONE))
        else $error("invalid result with nonzero payload");

    // Status results lie in the point range or the status address range.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == CAT_STATUS) |->
        (m_axis_tdata <= FWD_STATUS_HI ||
         (m_axis_tdata >= REV_STATUS_LO && m_axis_tdata <= REV_STATUS_HI)))
        else $error("status result out of range");

    // Pseudo results lie in the pseudo address range or the pseudo point range.
    a_pseudo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == CAT_PSEUDO) |->
        ((m_axis_tdata >= REV_PSEUDO_LO && m_axis_tdata <= REV_PSEUDO_HI) ||
         (m_axis_tdata >= FWD_PSEUDO_LO && m_axis_tdata <= FWD_PSEUDO_HI)))
        else $error("pseudo result out of range");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind point_bitbyte_address_mapper_core pbam_checker u_pbam_checker (.*);

// File: tb/tb.sv
// Stream-level self-checking testbench for the point / bit-byte address mapper core.
`timescale 1ns / 1ps

module tb
    import pbam_pkg::*;
();

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 400;   // results taken before the long hold-off
    localparam int HOLD_CYCLES  = 240;
    localparam int PAUSE_AT     = 900;   // random item before which the sender drains

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] number_in
    logic        s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] number_out
    logic [2:0]  m_axis_tuser;   // [0] valid_res, [2:1] category

    // One row of the directed table. When known is set, the expected result is
    // taken from the row; otherwise it comes from the translation predictor.
    typedef struct packed {
        t_direction  dir;
        logic [15:0] num;
        logic        known;
        logic        valid;
        logic [15:0] number;
        t_category   category;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 26;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{DIR_FWD, 16'd0,     1'b1, 1'b1, 16'd8193,  CAT_STATUS},
        '{DIR_FWD, 16'd2047,  1'b1, 1'b1, 16'd10240, CAT_STATUS},
        '{DIR_FWD, 16'd2048,  1'b1, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_FWD, 16'd10000, 1'b1, 1'b1, 16'd0,     CAT_TWOWAY},
        '{DIR_FWD, 16'd11023, 1'b1, 1'b1, 16'd2046,  CAT_TWOWAY},
        '{DIR_FWD, 16'd15000, 1'b1, 1'b1, 16'd2048,  CAT_NONE},
        '{DIR_FWD, 16'd16023, 1'b0, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_FWD, 16'd25000, 1'b1, 1'b1, 16'd4608,  CAT_NONE},
        '{DIR_FWD, 16'd25063, 1'b0, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_FWD, 16'd36000, 1'b1, 1'b1, 16'd5632,  CAT_NONE},
        '{DIR_FWD, 16'd36088, 1'b1, 1'b1, 16'd5808,  CAT_NONE},
        '{DIR_FWD, 16'd36095, 1'b0, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_FWD, 16'd50000, 1'b1, 1'b1, 16'd7000,  CAT_PSEUDO},
        '{DIR_FWD, 16'd51192, 1'b1, 1'b1, 16'd8192,  CAT_PSEUDO},
        '{DIR_FWD, 16'd65535, 1'b1, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_REV, 16'd0,     1'b1, 1'b1, 16'd10000, CAT_TWOWAY},
        '{DIR_REV, 16'd1,     1'b1, 1'b0, 16'd0,     CAT_NONE},    // odd digital address
        '{DIR_REV, 16'd4095,  1'b1, 1'b0, 16'd0,     CAT_NONE},    // odd digital-analog address
        '{DIR_REV, 16'd4616,  1'b1, 1'b0, 16'd0,     CAT_NONE},    // block slot offset 8
        '{DIR_REV, 16'd4727,  1'b0, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_REV, 16'd5751,  1'b0, 1'b0, 16'd0,     CAT_NONE},
        '{DIR_REV, 16'd5808,  1'b1, 1'b1, 16'd36088, CAT_NONE},
        '{DIR_REV, 16'd7000,  1'b1, 1'b1, 16'd50000, CAT_PSEUDO},
        '{DIR_REV, 16'd8193,  1'b1, 1'b1, 16'd0,     CAT_STATUS},
        '{DIR_REV, 16'd10240, 1'b1, 1'b1, 16'd2047,  CAT_STATUS},
        '{DIR_REV, 16'd65535, 1'b1, 1'b0, 16'd0,     CAT_NONE}
    };

    t_result pending_results[$];
    int      error_count   = 0;
    int      cycle_count   = 0;
    int      results_taken = 0;
    bit      hold_active   = 1'b0;

    point_bitbyte_address_mapper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Translation predictor: the valid flag, the mapped number and the category
    // of one number in the chosen direction. Anything unmapped stays all zero.
    function automatic t_result translate_number(t_direction dir, logic [15:0] num);
        t_result r;
        int      n;
        int      d;
        r.valid    = 1'b0;
        r.number   = 16'd0;
        r.category = CAT_NONE;
        n = int'(num);
        if (dir == DIR_FWD) begin
            if (n <= FWD_STATUS_HI) begin
                r.valid = 1'b1; r.number = 16'(REV_STATUS_LO + n); r.category = CAT_STATUS;
            end else if (n >= FWD_DIG_LO && n <= FWD_DIG_HI) begin
                r.valid = 1'b1; r.number = 16'((n - FWD_DIG_LO) * 2); r.category = CAT_TWOWAY;
            end else if (n >= FWD_DA_LO && n <= FWD_DA_HI) begin
                r.valid = 1'b1; r.number = 16'((n - FWD_DA_LO) * 2 + REV_DIG_HI + 1);
            end else if (n >= FWD_BLK0_LO && n <= FWD_BLK0_HI) begin
                // Eight points fill the low half of each sixteen-slot block.
                d = n - FWD_BLK0_LO;
                r.valid = 1'b1; r.number = 16'(REV_BLK0_LO + (d / 8) * 16 + d % 8);
            end else if (n >= FWD_BLK1_LO && n <= FWD_BLK1_HI) begin
                d = n - FWD_BLK1_LO;
                r.valid = 1'b1; r.number = 16'(REV_BLK1_LO + (d / 8) * 16 + d % 8);
            end else if (n >= FWD_BLK2_LO && n <= FWD_BLK2_HI) begin
                r.valid = 1'b1; r.number = 16'(REV_BLK2_LO + n - FWD_BLK2_LO);
            end else if (n >= FWD_PSEUDO_LO && n <= FWD_PSEUDO_HI) begin
                r.valid = 1'b1; r.number = 16'(REV_PSEUDO_LO + n - FWD_PSEUDO_LO);
                r.category = CAT_PSEUDO;
            end
        end else begin
            if (n <= REV_DIG_HI) begin
                if (!num[0]) begin
                    r.valid = 1'b1; r.number = 16'(FWD_DIG_LO + n / 2);
                    r.category = CAT_TWOWAY;
                end
            end else if (n <= REV_DA_HI) begin
                if (!num[0]) begin
                    r.valid = 1'b1; r.number = 16'(FWD_DA_LO + (n - REV_DIG_HI - 1) / 2);
                end
            end else if (n >= REV_BLK0_LO && n <= REV_BLK0_HI) begin
                d = n - REV_BLK0_LO;
                if (d % 16 < 8) begin
                    r.valid = 1'b1; r.number = 16'(FWD_BLK0_LO + (d / 16) * 8 + d % 16);
                end
            end else if (n >= REV_BLK1_LO && n <= REV_BLK1_HI) begin
                d = n - REV_BLK1_LO;
                if (d % 16 < 8) begin
                    r.valid = 1'b1; r.number = 16'(FWD_BLK1_LO + (d / 16) * 8 + d % 16);
                end
            end else if (n >= REV_BLK2_LO && n <= REV_BLK2_HI) begin
                r.valid = 1'b1; r.number = 16'(FWD_BLK2_LO + n - REV_BLK2_LO);
            end else if (n >= REV_PSEUDO_LO && n <= REV_PSEUDO_HI) begin
                r.valid = 1'b1; r.number = 16'(FWD_PSEUDO_LO + n - REV_PSEUDO_LO);
                r.category = CAT_PSEUDO;
            end else if (n >= REV_STATUS_LO && n <= REV_STATUS_HI) begin
                r.valid = 1'b1; r.number = 16'(n - REV_STATUS_LO); r.category = CAT_STATUS;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at time %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Most random numbers land in or just around a mapped range of the chosen
    // direction; the rest are arbitrary 16-bit values.
    task automatic pick_random_number(output t_direction dir, output logic [15:0] num);
        int fwd_lo [7] = '{0, FWD_DIG_LO, FWD_DA_LO, FWD_BLK0_LO, FWD_BLK1_LO,
                           FWD_BLK2_LO, FWD_PSEUDO_LO};
        int fwd_hi [7] = '{FWD_STATUS_HI, FWD_DIG_HI, FWD_DA_HI, FWD_BLK0_HI,
                           FWD_BLK1_HI, FWD_BLK2_HI, FWD_PSEUDO_HI};
        int rev_lo [7] = '{0, REV_DIG_HI + 1, REV_BLK0_LO, REV_BLK1_LO, REV_BLK2_LO,
                           REV_PSEUDO_LO, REV_STATUS_LO};
        int rev_hi [7] = '{REV_DIG_HI, REV_DA_HI, REV_BLK0_HI, REV_BLK1_HI,
                           REV_BLK2_HI, REV_PSEUDO_HI, REV_STATUS_HI};
        int idx;
        int lo;
        int hi;
        dir = $urandom_range(0, 1) ? DIR_REV : DIR_FWD;
        if ($urandom_range(0, 9) < 3) begin
            num = 16'($urandom);
        end else begin
            idx = $urandom_range(0, 6);
            lo  = (dir == DIR_FWD) ? fwd_lo[idx] : rev_lo[idx];
            hi  = (dir == DIR_FWD) ? fwd_hi[idx] : rev_hi[idx];
            lo  = (lo >= 2) ? lo - 2 : 0;
            hi  = (hi <= 65533) ? hi + 2 : 65535;
            num = 16'($urandom_range(hi, lo));
        end
    endtask

    // Sender gap: none while the receiver holds off, and none in every fourth
    // window of 50 transfers, so back-to-back stretches occur too.
    function automatic int sender_gap(int idx);
        if (hold_active || ((idx / 50) % 4 == 3))
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Offers one item after its gap and records the expectation on acceptance.
    task automatic offer_item(input int idx, input t_direction dir, input logic [15:0] num,
                              input t_result exp_r);
        int gap;
        gap = sender_gap(idx);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= num;
        s_axis_tuser  <= dir;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(exp_r);
    endtask

    // Stimulus: reset, the directed table, then random numbers.
    initial begin
        t_result    exp_r;
        t_direction dir;
        logic [15:0] num;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].known) begin
                exp_r.valid    = directed_rows[i].valid;
                exp_r.number   = directed_rows[i].number;
                exp_r.category = directed_rows[i].category;
            end else begin
                exp_r = translate_number(directed_rows[i].dir, directed_rows[i].num);
            end
            offer_item(i, directed_rows[i].dir, directed_rows[i].num, exp_r);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == PAUSE_AT) begin
                // Let the pipeline run completely dry before going on.
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            pick_random_number(dir, num);
            offer_item(i, dir, num, translate_number(dir, num));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: a random stall before each transfer, quiet windows without
    // stalls, and one long hold-off that backs the block up into its input.
    initial begin
        int  stall;
        bit  held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ((results_taken / 60) % 4 == 2) ? 0 : $urandom_range(0, 14);
            if (results_taken >= HOLD_AT && !held) begin
                held        = 1'b1;
                hold_active = 1'b1;
                stall       = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            hold_active = 1'b0;
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            results_taken++;
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (number %0d)",
                                          m_axis_tdata));
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser[0] !== exp_r.valid)
                    report_mismatch($sformatf("valid_res expected %0d got %0b",
                                              exp_r.valid, m_axis_tuser[0]));
                if (m_axis_tdata !== exp_r.number)
                    report_mismatch($sformatf("number_out expected %0d got %0d",
                                              exp_r.number, m_axis_tdata));
                if (m_axis_tuser[2:1] !== exp_r.category)
                    report_mismatch($sformatf("category expected %0d got %0d",
                                              exp_r.category, m_axis_tuser[2:1]));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/core/pbam_pkg.sv
rtl/core/pbam_fwd.sv
rtl/core/pbam_rev.sv
rtl/core/point_bitbyte_address_mapper_core.sv
rtl/core/pbam_checker.sv
tb/tb.sv
